>>> rtl/sdd_pkg.sv
// sdd_pkg: shared types and constants for the subspace departure detector
// used by sdd_ctrl, sdd_dpath, sdd_checker and the top level; no dependencies
package sdd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 2;
  localparam int DIST_W      = 31;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int ROUND_HALF  = 16384;

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] THRESH_RST = DIST_W'(1073741824);

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_AW-3:0] REG_THRESH = '0;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    MUL_MAC,
    MUL_OLD,
    MUL_NEW
  } mul_sel_t;

  typedef struct packed {
    logic     take;
    logic     load;
    logic     win_we;
    mul_sel_t mul_sel;
    logic     old_mask;
    logic     mac_v;
    logic     mac_mask;
    logic     mac_first;
    logic     mac_last;
    logic     mac_final;
    logic     en_sub;
    logic     en_add;
    logic     proj_clr;
    logic     diff;
    logic     div_init;
    logic     out_load;
    logic     full;
  } dp_cmd_t;

  typedef struct packed {
    logic proj_done;
  } dp_stat_t;

endpackage

>>> rtl/sdd_dpath.sv
// sdd_dpath: window and basis memories, shared multiply-accumulate pipeline,
// energy bookkeeping, clamp and shift divide by the window length
// depends on sdd_pkg; driven by sdd_ctrl
module sdd_dpath import sdd_pkg::*; #(
  parameter int WINDOW_LEN = 32,
  parameter int STAT_DIM   = 4,
  parameter int KB         = $clog2(WINDOW_LEN),
  parameter int DB         = (STAT_DIM > 1) ? $clog2(STAT_DIM) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [ROW_W-1:0]           in_basis_row,
  input  logic [COL_W-1:0]           in_basis_col,
  input  logic signed [COEF_W-1:0]   in_basis_value,
  input  logic [KB-1:0]              win_raddr,
  input  logic [KB-1:0]              win_waddr,
  input  logic [KB+DB-1:0]           bas_raddr,
  input  logic [DIST_W-1:0]          thresh,
  output logic [DIST_W-1:0]          out_distance,
  output logic                       out_alarm,
  output logic                       out_window_full
);

  localparam int EW = KB + 31;
  localparam int AW = KB + 32;
  localparam int CW = AW - 15;
  localparam int SB = $clog2(STAT_DIM + 1);
  localparam int PW = 2 * CW + SB;
  localparam int DW = ((EW > PW) ? EW : PW) + 1;
  localparam int BD = 1 << (KB + DB);
  localparam logic [DW-1:0] DIV_LIM = DW'(WINDOW_LEN) << DIST_W;

  logic signed [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
  logic signed [COEF_W-1:0]   bas_mem [BD];

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] win_q_r;
  logic signed [COEF_W-1:0]   bas_q_r;
  logic signed [31:0]         prod_r;
  logic signed [AW-1:0]       acc_r;
  logic signed [CW-1:0]       coord_r;
  logic signed [2*CW-1:0]     sq_r;
  logic [PW-1:0]              proj_r;
  logic [EW-1:0]              energy_r;
  logic [DW-1:0]              diff_r;
  logic                       sat_r;
  logic [DIST_W-1:0]          quo_r;
  logic [DIST_W-1:0]          dist_r;
  logic                       alarm_r;
  logic                       full_r;

  // pipeline tags: p1 = memory read, p2 = product, p3 = accumulator,
  // c = rounded coordinate, s = squared coordinate
  logic p1_v_r, p1_mask_r, p1_first_r, p1_last_r, p1_final_r;
  logic p2_v_r, p2_first_r, p2_last_r, p2_final_r;
  logic p3_v_r, p3_last_r, p3_final_r;
  logic c_v_r, c_final_r;
  logic s_v_r, s_final_r;
  logic proj_done_r;

  logic                       bas_we;
  logic [KB+DB-1:0]           bas_waddr;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [AW-1:0]       rnd;
  logic [DW-1:0]              dsub;
  logic [DIST_W-1:0]          dist_nxt;

  assign bas_we    = cmd.load && (32'(in_basis_row) < WINDOW_LEN)
                     && (32'(in_basis_col) < STAT_DIM);
  assign bas_waddr = {KB'(in_basis_row), DB'(in_basis_col)};

  always_ff @(posedge clk) begin
    if (cmd.win_we) begin
      win_mem[win_waddr] <= sample_r;
    end
    win_q_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (bas_we) begin
      bas_mem[bas_waddr] <= in_basis_value;
    end
    bas_q_r <= bas_mem[bas_raddr];
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_OLD: begin
        mul_a = cmd.old_mask ? win_q_r : '0;
        mul_b = mul_a;
      end
      MUL_NEW: begin
        mul_a = sample_r;
        mul_b = sample_r;
      end
      default: begin
        mul_a = p1_mask_r ? win_q_r : '0;
        mul_b = bas_q_r;
      end
    endcase
  end

  assign rnd  = acc_r + AW'(ROUND_HALF);
  assign dsub = DW'(energy_r) - DW'(proj_r);

  assign dist_nxt = sat_r ? DIST_MAX : quo_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r <= in_sample;
    end
    prod_r  <= mul_a * mul_b;
    coord_r <= $signed(rnd[AW-1:15]);
    sq_r    <= coord_r * coord_r;
    if (p2_v_r) begin
      acc_r <= p2_first_r ? AW'(prod_r) : acc_r + AW'(prod_r);
    end
    if (cmd.diff) begin
      diff_r <= dsub[DW-1] ? '0 : dsub;
    end
    if (cmd.div_init) begin
      // floor divide by the window length: drop the low KB bits
      sat_r <= (diff_r >= DIV_LIM);
      quo_r <= diff_r[KB +: DIST_W];
    end
    if (cmd.out_load) begin
      dist_r  <= dist_nxt;
      alarm_r <= (dist_nxt > thresh);
      full_r  <= cmd.full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r    <= '0;
      proj_r      <= '0;
      p1_v_r      <= 1'b0;
      p1_mask_r   <= 1'b0;
      p1_first_r  <= 1'b0;
      p1_last_r   <= 1'b0;
      p1_final_r  <= 1'b0;
      p2_v_r      <= 1'b0;
      p2_first_r  <= 1'b0;
      p2_last_r   <= 1'b0;
      p2_final_r  <= 1'b0;
      p3_v_r      <= 1'b0;
      p3_last_r   <= 1'b0;
      p3_final_r  <= 1'b0;
      c_v_r       <= 1'b0;
      c_final_r   <= 1'b0;
      s_v_r       <= 1'b0;
      s_final_r   <= 1'b0;
      proj_done_r <= 1'b0;
    end else begin
      // the evicted sample is always part of the energy, so no underflow
      if (cmd.en_sub) begin
        energy_r <= energy_r - EW'(prod_r[30:0]);
      end else if (cmd.en_add) begin
        energy_r <= energy_r + EW'(prod_r[30:0]);
      end
      if (cmd.proj_clr) begin
        proj_r <= '0;
      end else if (s_v_r) begin
        proj_r <= proj_r + PW'(unsigned'(sq_r));
      end
      p1_v_r      <= cmd.mac_v;
      p1_mask_r   <= cmd.mac_mask;
      p1_first_r  <= cmd.mac_first;
      p1_last_r   <= cmd.mac_last;
      p1_final_r  <= cmd.mac_final;
      p2_v_r      <= p1_v_r;
      p2_first_r  <= p1_first_r;
      p2_last_r   <= p1_last_r;
      p2_final_r  <= p1_final_r;
      p3_v_r      <= p2_v_r;
      p3_last_r   <= p2_last_r;
      p3_final_r  <= p2_final_r;
      c_v_r       <= p3_v_r && p3_last_r;
      c_final_r   <= p3_final_r;
      s_v_r       <= c_v_r;
      s_final_r   <= c_final_r;
      proj_done_r <= s_v_r && s_final_r;
    end
  end

  assign stat.proj_done  = proj_done_r;
  assign out_distance    = dist_r;
  assign out_alarm       = alarm_r;
  assign out_window_full = full_r;

endmodule

>>> rtl/sdd_ctrl.sv
// sdd_ctrl: sequencer for one item; window pointer, fill count, column and
// row counters and the result valid flag
// depends on sdd_pkg; commands sdd_dpath
module sdd_ctrl import sdd_pkg::*; #(
  parameter int WINDOW_LEN = 32,
  parameter int STAT_DIM   = 4,
  parameter int KB         = $clog2(WINDOW_LEN),
  parameter int DB         = (STAT_DIM > 1) ? $clog2(STAT_DIM) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          cmd,
  input  dp_stat_t         stat,
  output logic [KB-1:0]    win_raddr,
  output logic [KB-1:0]    win_waddr,
  output logic [KB+DB-1:0] bas_raddr
);

  localparam int FB = $clog2(WINDOW_LEN + 1);
  localparam logic [KB-1:0] K_LAST = KB'(WINDOW_LEN - 1);
  localparam logic [DB-1:0] D_LAST = DB'(STAT_DIM - 1);
  localparam logic [FB-1:0] F_FULL = FB'(WINDOW_LEN);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OLD_SQ,
    S_NEW_SQ,
    S_EN_ADD,
    S_MAC,
    S_DRAIN,
    S_DIFF,
    S_DIV_INIT,
    S_DONE
  } state_t;

  state_t        state_r;
  logic [KB-1:0] wp_r;
  logic [KB-1:0] rp_r;
  logic [KB-1:0] k_r;
  logic [DB-1:0] d_r;
  logic [FB-1:0] fill_r;
  logic          out_valid_r;

  logic          full_now;
  logic          out_free;
  logic [KB-1:0] wp_inc;
  logic [KB-1:0] rp_inc;

  assign full_now = (fill_r == F_FULL);
  assign out_free = !out_valid_r || out_ready;
  assign wp_inc   = (wp_r == K_LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc   = (rp_r == K_LAST) ? '0 : rp_r + 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign win_raddr = (state_r == S_MAC) ? rp_r : wp_r;
  assign win_waddr = wp_r;
  assign bas_raddr = {k_r, d_r};

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = (in_op == OP_LOAD);
          cmd.take = (in_op == OP_SAMPLE);
        end
      end
      S_OLD_SQ: begin
        cmd.win_we   = 1'b1;
        cmd.mul_sel  = MUL_OLD;
        cmd.old_mask = full_now;
      end
      S_NEW_SQ: begin
        cmd.en_sub  = 1'b1;
        cmd.mul_sel = MUL_NEW;
      end
      S_EN_ADD: begin
        cmd.en_add   = 1'b1;
        cmd.proj_clr = 1'b1;
      end
      S_MAC: begin
        cmd.mac_v     = 1'b1;
        // slots not yet filled since reset read as zero
        cmd.mac_mask  = ((FB+1)'(k_r) + (FB+1)'(fill_r)) >= (FB+1)'(WINDOW_LEN);
        cmd.mac_first = (k_r == '0);
        cmd.mac_last  = (k_r == K_LAST);
        cmd.mac_final = (k_r == K_LAST) && (d_r == D_LAST);
      end
      S_DRAIN: begin
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = out_free;
        cmd.full     = full_now;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      k_r         <= '0;
      d_r         <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && (in_op == OP_SAMPLE)) begin
            state_r <= S_OLD_SQ;
          end
        end
        S_OLD_SQ: begin
          wp_r    <= wp_inc;
          fill_r  <= full_now ? fill_r : fill_r + 1'b1;
          state_r <= S_NEW_SQ;
        end
        S_NEW_SQ: begin
          state_r <= S_EN_ADD;
        end
        S_EN_ADD: begin
          k_r     <= '0;
          d_r     <= '0;
          rp_r    <= wp_r;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (k_r == K_LAST) begin
            k_r  <= '0;
            rp_r <= wp_r;
            if (d_r == D_LAST) begin
              state_r <= S_DRAIN;
            end else begin
              d_r <= d_r + 1'b1;
            end
          end else begin
            k_r  <= k_r + 1'b1;
            rp_r <= rp_inc;
          end
        end
        S_DRAIN: begin
          if (stat.proj_done) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          state_r <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/subspace_departure_detector.sv
// subspace departure detector, top level: stream ports, threshold register,
// controller and datapath
// depends on sdd_pkg, sdd_ctrl, sdd_dpath
//
// usage:
//   in_* carries one word per item. in_tuser = 0 scores in_tdata's sample,
//   in_tuser = 1 loads one Q1.15 basis entry (row, column, value); loads
//   outside the basis are dropped. a load keeps in_tready high, gives no word.
//   a sample shifts into the window and gives one out_* word: distance, alarm
//   (distance above the threshold register) and window full.
//   a sample is scored by the single multiply-accumulate unit that walks
//   every window entry of every basis column. the divide by WINDOW_LEN is
//   a shift, so WINDOW_LEN must be a power of two; the block itself does
//   not check this. one item is worked at a time, and the next item is
//   taken in the cycle after a result is loaded into the output register.
//   a result waits in an output register; if the receiver stalls past the
//   next result, that result waits in the sequencer and in_tready stays low.
//   reset empties the window and clears its energy, fill count and threshold
//   (to 2^30); basis entries must be loaded before a score reads them.
//   cfg_*: byte address 0 holds alarm_threshold; pready is always high.
module subspace_departure_detector import sdd_pkg::*; #(
  parameter int WINDOW_LEN = 32,
  parameter int STAT_DIM   = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sample[15:0], basis_row[20:16], basis_col[22:21], basis_value[38:23], zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // distance[30:0], alarm[31], window_full[32], zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int KB = $clog2(WINDOW_LEN);
  localparam int DB = (STAT_DIM > 1) ? $clog2(STAT_DIM) : 1;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [KB-1:0]     win_raddr;
  logic [KB-1:0]     win_waddr;
  logic [KB+DB-1:0]  bas_raddr;
  logic [DIST_W-1:0] thresh_r;
  logic [DIST_W-1:0] distance;
  logic              alarm;
  logic              window_full;
  logic              reg_hit;

  assign reg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_THRESH);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? CFG_DW'(thresh_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      thresh_r <= cfg_pwdata[DIST_W-1:0];
    end
  end

  sdd_ctrl #(
    .WINDOW_LEN (WINDOW_LEN),
    .STAT_DIM   (STAT_DIM),
    .KB         (KB),
    .DB         (DB)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .stat      (stat),
    .win_raddr (win_raddr),
    .win_waddr (win_waddr),
    .bas_raddr (bas_raddr)
  );

  sdd_dpath #(
    .WINDOW_LEN (WINDOW_LEN),
    .STAT_DIM   (STAT_DIM),
    .KB         (KB),
    .DB         (DB)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample       ($signed(in_tdata[15:0])),
    .in_basis_row    (in_tdata[20:16]),
    .in_basis_col    (in_tdata[22:21]),
    .in_basis_value  ($signed(in_tdata[38:23])),
    .win_raddr       (win_raddr),
    .win_waddr       (win_waddr),
    .bas_raddr       (bas_raddr),
    .thresh          (thresh_r),
    .out_distance    (distance),
    .out_alarm       (alarm),
    .out_window_full (window_full)
  );

  assign out_tdata = {{(OUT_TDATA_W-DIST_W-2){1'b0}}, window_full, alarm, distance};

endmodule

>>> rtl/sdd_checker.sv
// sdd_checker: port-level assertions for the subspace departure detector
// depends on sdd_pkg; bound to subspace_departure_detector below
module sdd_checker import sdd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a scored sample occupies the sequencer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_SAMPLE) |=> !in_tready)
    else $error("input taken while a sample is being scored");

  // a basis load finishes in its accept cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_LOAD) |=> in_tready)
    else $error("basis load stalled the input");

  a_alarm_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DIST_W] |-> (out_tdata[DIST_W-1:0] != '0))
    else $error("alarm with zero distance");

endmodule

bind subspace_departure_detector sdd_checker u_sdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
